>>> rtl/hsl_pkg.sv
// Shared types and constants for the HSL to RGB pixel converter.
package hsl_pkg;

  // Fixed-point format: all unit values are Q1.FracBits.
  localparam int FracBits = 16;
  localparam int HueW     = FracBits;
  localparam int UnitW    = FracBits + 1;
  localparam int One      = 1 << FracBits;
  localparam longint unsigned OneSq = 64'd1 << (2 * FracBits);

  // Hue times six: three extra integer bits hold the sector number.
  localparam int H6W   = HueW + 3;
  // Signed 2*c - 1 and the wide signed products built from it.
  localparam int DiffW = UnitW + 2;
  localparam int ProdW = DiffW + UnitW + 1;
  localparam int LumPW = 2 * UnitW;

  typedef logic [HueW-1:0]  hue_t;
  typedef logic [UnitW-1:0] unit_t;

  // The six sectors of the color wheel.
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } hsl_stage_en_t;

endpackage

>>> rtl/hsl_ifs.sv
// Valid/ready channel interfaces for HSL input words and RGB output words.
interface hsl_in_if;
  import hsl_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue;
  unit_t saturation;
  unit_t lumination;

  modport source (output valid, output hue, output saturation, output lumination,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lumination,
                  output ready);
endinterface

interface hsl_out_if;
  import hsl_pkg::*;

  logic  valid;
  logic  ready;
  unit_t red;
  unit_t green;
  unit_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/hsl_chan_pipe.sv
// Saturation and lumination pipeline (stages two to five) for one color channel.
module hsl_chan_pipe (
  input  logic                  clk_i,
  input  hsl_pkg::hsl_stage_en_t en_i,
  input  hsl_pkg::unit_t        c_i,
  input  hsl_pkg::unit_t        sat_i,
  input  hsl_pkg::unit_t        lum_i,
  output hsl_pkg::unit_t        c_o
);
  import hsl_pkg::*;

  // Stage 2: s * (2c - 1).
  logic signed [DiffW-1:0] diff2;
  logic signed [ProdW-1:0] sp_d, sp_q;
  unit_t                   lum2_q;

  // Stage 3: round back to unit scale.
  logic [ProdW-1:0] sn3;
  unit_t            c3_d, c3_q;
  unit_t            lum3_q;
  logic             hi3_d, hi3_q;

  // Stage 4: lumination product.
  unit_t             m4;
  logic [LumPW-1:0]  lp_d, lp_q;
  unit_t             c4_q;
  logic              hi4_q;

  // Stage 5: offset for the upper half and final rounding.
  logic signed [DiffW-1:0] diff5;
  logic signed [ProdW-1:0] off5;
  logic        [ProdW-1:0] sum5;
  unit_t                   c5_d, c5_q;

  assign diff2 = $signed({1'b0, c_i, 1'b0}) - $signed(DiffW'(One));
  assign sp_d  = ProdW'($signed({1'b0, sat_i})) * ProdW'(diff2);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sp_q   <= sp_d;
      lum2_q <= lum_i;
    end
  end

  // The saturated value never drops below zero, so no clamp is needed here.
  assign sn3   = sp_q + ProdW'(OneSq) + ProdW'(One);
  assign c3_d  = sn3[2*FracBits+1 -: UnitW];
  assign hi3_d = (lum2_q > UnitW'(One / 2));

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      c3_q   <= c3_d;
      lum3_q <= lum2_q;
      hi3_q  <= hi3_d;
    end
  end

  // Above one half the product uses 1 - c instead of c.
  assign m4   = hi3_q ? (UnitW'(One) - c3_q) : c3_q;
  assign lp_d = LumPW'(m4) * LumPW'(lum3_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      lp_q  <= lp_d;
      c4_q  <= c3_q;
      hi4_q <= hi3_q;
    end
  end

  assign diff5 = $signed({1'b0, c4_q, 1'b0}) - $signed(DiffW'(One));
  assign off5  = hi4_q ? (ProdW'(diff5) <<< FracBits) : '0;
  assign sum5  = ProdW'({lp_q, 1'b0}) + off5 + ProdW'(One / 2);
  assign c5_d  = sum5[2*FracBits -: UnitW];

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      c5_q <= c5_d;
    end
  end

  assign c_o = c5_q;

endmodule

>>> rtl/hsl_to_rgb_pixel.sv
// Top level of the HSL to RGB pixel converter.
//
// One word on the in_i channel carries hue (0.16, a fraction of a full turn),
// saturation and lumination (Q1.16, 65536 is 1.0; larger codes clamp to 1.0).
// One word on the out_o channel carries red, green and blue in Q1.16.
// Both channels move a word at a rising edge with valid and ready high.
//
// The datapath is a five-stage pipeline: sector decode and clamping, the
// saturation multiply, its rounding, the lumination multiply, and the final
// offset and rounding into the output register. A word moves through these
// stage registers in that order and shows on out_o from the last of them;
// while the receiver does not stall, a new word can be accepted at every
// edge, so throughput is one pixel per cycle.
//
// Each stage holds its word until the next stage is free, so a stall of the
// receiver fills the empty stages first and in_i.ready drops only once all
// five stages hold words. Bubbles collapse; no word is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module hsl_to_rgb_pixel (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsl_in_if.sink     in_i,
  hsl_out_if.source  out_o
);
  import hsl_pkg::*;

  hsl_stage_en_t en;
  logic [4:0]    vld_d, vld_q;

  // Stage 1 signals.
  logic [H6W-1:0] h6;
  sector_e        sector;
  unit_t          frac, inv;
  unit_t          base_d [3];
  unit_t          base_q [3];
  unit_t          sat_d, sat_q, lum_d, lum_q;
  unit_t          chan_out [3];

  // A stage loads when it is empty or when its word moves on.
  assign en.s5 = !vld_q[4] || out_o.ready;
  assign en.s4 = !vld_q[3] || en.s5;
  assign en.s3 = !vld_q[2] || en.s4;
  assign en.s2 = !vld_q[1] || en.s3;
  assign en.s1 = !vld_q[0] || en.s2;

  assign in_i.ready = en.s1;

  assign vld_d[0] = en.s1 ? in_i.valid : vld_q[0];
  assign vld_d[1] = en.s2 ? vld_q[0]   : vld_q[1];
  assign vld_d[2] = en.s3 ? vld_q[1]   : vld_q[2];
  assign vld_d[3] = en.s4 ? vld_q[2]   : vld_q[3];
  assign vld_d[4] = en.s5 ? vld_q[3]   : vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Six times the hue: the integer part is the sector, the rest the ramp.
  assign h6     = (H6W'(in_i.hue) << 2) + (H6W'(in_i.hue) << 1);
  assign sector = sector_e'(h6[H6W-1:HueW]);
  assign frac   = UnitW'(h6[HueW-1:0]);
  assign inv    = UnitW'(One) - frac;

  always_comb begin
    case (sector)
      SecRed: begin
        base_d[0] = UnitW'(One); base_d[1] = frac;        base_d[2] = '0;
      end
      SecYellow: begin
        base_d[0] = inv;         base_d[1] = UnitW'(One); base_d[2] = '0;
      end
      SecGreen: begin
        base_d[0] = '0;          base_d[1] = UnitW'(One); base_d[2] = frac;
      end
      SecCyan: begin
        base_d[0] = '0;          base_d[1] = inv;         base_d[2] = UnitW'(One);
      end
      SecBlue: begin
        base_d[0] = frac;        base_d[1] = '0;          base_d[2] = UnitW'(One);
      end
      SecMagenta: begin
        base_d[0] = UnitW'(One); base_d[1] = '0;          base_d[2] = inv;
      end
      default: begin
        base_d[0] = UnitW'(One); base_d[1] = '0;          base_d[2] = inv;
      end
    endcase
  end

  // Saturation and lumination above 1.0 are clamped.
  assign sat_d = (in_i.saturation > UnitW'(One)) ? UnitW'(One) : in_i.saturation;
  assign lum_d = (in_i.lumination > UnitW'(One)) ? UnitW'(One) : in_i.lumination;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      base_q <= base_d;
      sat_q  <= sat_d;
      lum_q  <= lum_d;
    end
  end

  // The three channels run through identical saturation/lumination pipes.
  for (genvar g = 0; g < 3; g++) begin : g_chan
    hsl_chan_pipe u_chan (
      .clk_i (clk_i),
      .en_i  (en),
      .c_i   (base_q[g]),
      .sat_i (sat_q),
      .lum_i (lum_q),
      .c_o   (chan_out[g])
    );
  end

  assign out_o.valid = vld_q[4];
  assign out_o.red   = chan_out[0];
  assign out_o.green = chan_out[1];
  assign out_o.blue  = chan_out[2];

endmodule

>>> rtl/hsl_chk.sv
// Port-level assertions for the HSL to RGB pixel converter, bound to the top level.
module hsl_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input hsl_pkg::unit_t red_i,
  input hsl_pkg::unit_t green_i,
  input hsl_pkg::unit_t blue_i
);
  import hsl_pkg::*;

  // A stalled output word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its colors.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("output word changed while stalled");

  // Every channel stays within 0 to 1.0.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> red_i <= UnitW'(One) && green_i <= UnitW'(One) &&
                    blue_i <= UnitW'(One))
    else $error("color channel above 1.0");

  // With the receiver ready every stage can advance, so the input is ready too.
  a_ready_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled although the output is ready");

  // Input valid is observed for completeness of the port set.
  a_in_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$isunknown(in_ready_i))
    else $error("input ready unknown after an accepted word");

endmodule

bind hsl_to_rgb_pixel hsl_chk u_hsl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red),
  .green_i     (out_o.green),
  .blue_i      (out_o.blue)
);

>>> bench/testbench.sv
// Self-checking bench for the HSL to RGB pixel converter: random and corner pixels, bursty traffic.
`timescale 1ns / 1ps

module testbench;
  import hsl_pkg::*;

  localparam longint UNIT     = One;
  localparam int     MaxCycle = 200000;
  localparam int     NumRand  = 1300;

  typedef struct {
    hue_t  hue;
    unit_t sat;
    unit_t lum;
  } hsl_word_t;

  typedef struct {
    unit_t red;
    unit_t green;
    unit_t blue;
  } rgb_word_t;

  logic clk_i;
  logic rst_ni;

  hsl_in_if  pix_in ();
  hsl_out_if rgb_out ();

  hsl_to_rgb_pixel dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_in),
    .out_o  (rgb_out)
  );

  hsl_word_t pending_q[$];
  rgb_word_t expected_rgb_q[$];

  int pixels_sent = 0;
  int rgb_checked = 0;
  int mismatches  = 0;
  int cycle_cnt   = 0;
  int num_directed;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Saturation pulls a channel toward one half, rounded to nearest, ties up.
  function automatic longint saturate_chan(longint c, longint s);
    longint num;
    num = s * (2 * c - UNIT) + UNIT * UNIT;
    if (num < 0) num = 0;
    return (num + UNIT) >>> (FracBits + 1);
  endfunction

  // Lumination darkens toward black below one half and brightens toward
  // white above it; exactly one half takes the darkening branch.
  function automatic longint luminate_chan(longint c, longint l);
    longint num;
    if (2 * l <= UNIT) begin
      num = 2 * c * l;
    end else begin
      num = 2 * (UNIT - c) * l + (2 * c - UNIT) * UNIT;
    end
    if (num < 0) num = 0;
    return (num + (UNIT >>> 1)) >>> FracBits;
  endfunction

  function automatic rgb_word_t predict_rgb(hsl_word_t px);
    longint    h6, ramp, s, l;
    longint    base[3];
    sector_e   sec;
    rgb_word_t res;
    s    = (px.sat > One) ? UNIT : longint'(px.sat);
    l    = (px.lum > One) ? UNIT : longint'(px.lum);
    h6   = 6 * longint'(px.hue);
    sec  = sector_e'(3'(h6 >>> FracBits));
    ramp = h6 - longint'(h6 >>> FracBits) * UNIT;
    case (sec)
      SecRed: begin
        base[0] = UNIT;        base[1] = ramp;        base[2] = 0;
      end
      SecYellow: begin
        base[0] = UNIT - ramp; base[1] = UNIT;        base[2] = 0;
      end
      SecGreen: begin
        base[0] = 0;           base[1] = UNIT;        base[2] = ramp;
      end
      SecCyan: begin
        base[0] = 0;           base[1] = UNIT - ramp; base[2] = UNIT;
      end
      SecBlue: begin
        base[0] = ramp;        base[1] = 0;           base[2] = UNIT;
      end
      default: begin
        base[0] = UNIT;        base[1] = 0;           base[2] = UNIT - ramp;
      end
    endcase
    res.red   = unit_t'(luminate_chan(saturate_chan(base[0], s), l));
    res.green = unit_t'(luminate_chan(saturate_chan(base[1], s), l));
    res.blue  = unit_t'(luminate_chan(saturate_chan(base[2], s), l));
    return res;
  endfunction

  function automatic void add_pixel(int h, int s, int l);
    hsl_word_t px;
    px.hue = hue_t'(h);
    px.sat = unit_t'(s);
    px.lum = unit_t'(l);
    pending_q.push_back(px);
  endfunction

  // Mostly legal unit codes, with a share of the ends, one half and codes
  // above one that the block has to clamp.
  function automatic int rand_unit();
    int pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1:    return $urandom_range(One + 1, 2 * One - 1);
      2:       return One;
      3:       return 0;
      4:       return One / 2;
      5:       return One / 2 + 1;
      default: return $urandom_range(0, One);
    endcase
  endfunction

  // Hue is mostly uniform, sometimes on or a step away from a sector edge.
  function automatic int rand_hue();
    int edge_idx;
    if ($urandom_range(0, 7) == 0) begin
      edge_idx = $urandom_range(0, 6);
      return (edge_idx * One / 6 + $urandom_range(0, 2) - 1) & (One - 1);
    end
    return $urandom_range(0, One - 1);
  endfunction

  // Sender: bursts of random length separated by random gaps. A word that is
  // offered stays on the channel unchanged until it is taken.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid      <= 1'b0;
      pix_in.hue        <= '0;
      pix_in.saturation <= '0;
      pix_in.lumination <= '0;
      burst_left        = 0;
      gap_left          = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        expected_rgb_q.push_back(predict_rgb(pending_q[0]));
        void'(pending_q.pop_front());
        pixels_sent++;
      end
      if (pix_in.valid && !pix_in.ready) begin
        // Hold the current word.
      end else if (gap_left > 0 || pending_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        pix_in.valid <= 1'b0;
      end else begin
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= pending_q[0].hue;
        pix_in.saturation <= pending_q[0].sat;
        pix_in.lumination <= pending_q[0].lum;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: the stall pattern is picked anew each time its phase counter
  // wraps. Once, after a few hundred words, it holds off long enough for the
  // pipeline to fill and push back on the sender.
  int  rx_phase;
  int  rx_mode;
  int  hold_left;
  bit  hold_done;
  logic next_ready;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_out.ready <= 1'b0;
      rx_phase      = 0;
      rx_mode       = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (!hold_done && pixels_sent >= 300) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (rx_phase == 0) rx_mode = $urandom_range(0, 3);
      rx_phase = (rx_phase + 1) % 64;
      case (rx_mode)
        0:       next_ready = 1'b1;
        1:       next_ready = $urandom_range(0, 1);
        2:       next_ready = (rx_phase % 3) != 0;
        default: next_ready = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end
      rgb_out.ready <= next_ready;
    end
  end

  // Each word taken from the block is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rgb_out.valid && rgb_out.ready) begin
      if (expected_rgb_q.size() == 0) begin
        $error("unexpected RGB word: red %0d green %0d blue %0d",
               rgb_out.red, rgb_out.green, rgb_out.blue);
        mismatches++;
      end else begin
        if (rgb_out.red !== expected_rgb_q[0].red) begin
          $error("red mismatch: expected %0d, got %0d", expected_rgb_q[0].red, rgb_out.red);
          mismatches++;
        end
        if (rgb_out.green !== expected_rgb_q[0].green) begin
          $error("green mismatch: expected %0d, got %0d",
                 expected_rgb_q[0].green, rgb_out.green);
          mismatches++;
        end
        if (rgb_out.blue !== expected_rgb_q[0].blue) begin
          $error("blue mismatch: expected %0d, got %0d", expected_rgb_q[0].blue, rgb_out.blue);
          mismatches++;
        end
        void'(expected_rgb_q.pop_front());
        rgb_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= MaxCycle) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, expected_rgb_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;

    // Corners: pure primaries and secondaries, both sides of each sector
    // edge, the half-lumination split, and clamped saturation and lumination.
    add_pixel(0, One, One / 2);
    add_pixel(One - 1, One, One / 2);
    add_pixel(10922, One, One / 2);
    add_pixel(10923, One, One / 2);
    add_pixel(21845, One, One / 2);
    add_pixel(21846, One, One / 2);
    add_pixel(32767, One, One / 2);
    add_pixel(32768, One, One / 2);
    add_pixel(43690, One, One / 2);
    add_pixel(43691, One, One / 2);
    add_pixel(54613, One, One / 2);
    add_pixel(54614, One, One / 2);
    add_pixel(5000, 0, 0);
    add_pixel(5000, 0, One);
    add_pixel(5000, 0, One / 2 + 1);
    add_pixel(20000, One, One);
    add_pixel(20000, One, 0);
    add_pixel(30000, One + 1, One / 2 - 1);
    add_pixel(40000, 2 * One - 1, 2 * One - 1);
    add_pixel(50000, One / 2, One + 1);
    add_pixel(60000, 2 * One - 1, One / 4);
    add_pixel(12345, 1, 1);
    add_pixel(65535, One - 1, One - 1);
    num_directed = pending_q.size();

    for (int i = 0; i < NumRand; i++) add_pixel(rand_hue(), rand_unit(), rand_unit());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || pix_in.valid) @(posedge clk_i);
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d pixels (%0d corner cases, the rest random) and checked %0d RGB words.",
             pixels_sent, num_directed, rgb_checked);
    $display("Traffic had bursty input, mixed output stalls and one long back-pressure hold.");
    if (mismatches == 0 && expected_rgb_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
